/* rtl/blsplit_pkg.sv */
// Shared types, codes and constants of the bracketed list splitter.
package blsplit_pkg;

    localparam int unsigned MAX_RECORD_LEN = 65536;
    localparam int unsigned POS_W = $clog2(MAX_RECORD_LEN + 1);
    localparam int unsigned OFS_W = 16;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam logic [7:0] CHAR_COLON  = 8'h3A;
    localparam logic [7:0] CHAR_LBRACK = 8'h5B;
    localparam logic [7:0] CHAR_RBRACK = 8'h5D;
    localparam logic [7:0] CHAR_LBRACE = 8'h7B;
    localparam logic [7:0] CHAR_RBRACE = 8'h7D;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_HT     = 8'h09;
    localparam logic [7:0] CHAR_CR     = 8'h0D;

    typedef enum logic [1:0] {
        MODE_WAIT   = 2'd0,
        MODE_ARRAY  = 2'd1,
        MODE_OBJECT = 2'd2,
        MODE_OTHER  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        KIND_ELEMENT = 2'd0,
        KIND_PAIR    = 2'd1,
        KIND_END     = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        RT_ARRAY        = 3'd0,
        RT_OBJECT       = 3'd1,
        RT_EMPTY_ARRAY  = 3'd2,
        RT_EMPTY_OBJECT = 3'd3,
        RT_UNKNOWN      = 3'd4
    } rtype_t;

    typedef struct packed {
        kind_t              kind;
        logic [OFS_W-1:0]   item_start;
        logic [OFS_W-1:0]   item_length;
        logic [OFS_W-1:0]   value_start;
        logic [OFS_W-1:0]   value_length;
        rtype_t             record_type;
        logic               status;
        logic               last_result;
    } result_t;

    typedef struct packed {
        logic    seg_valid;
        result_t seg_res;
        logic    end_valid;
        result_t end_res;
    } step_out_t;

    function automatic logic is_space(input logic [7:0] c);
        is_space = (c == CHAR_SPACE) || ((c >= CHAR_HT) && (c <= CHAR_CR));
    endfunction

endpackage

/* rtl/bracketed_list_splitter_core.sv */
// Top level of the bracketed list splitter: input register, parser and result queue.
//
//  Channel  Ports                                  Direction  Carries
//  s_       s_valid s_ready s_data_byte s_last_byte   in      one record byte a transaction
//  m_       m_valid m_ready m_kind ... m_last_result  out     element, pair and end items
//
// One byte is taken per cycle while s_ready is high; an accepted byte waits in the input
// register until the result queue can accept, is then parsed, and its results are queued.
// A closing byte that completes a segment gives two result transactions, which the
// four-entry result queue absorbs without stalling the input while m_ready stays high.
// The input stalls only when the result queue holds more than two transactions.
// Reset is synchronous and active low; it returns the parser to await a new record.
module bracketed_list_splitter_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [15:0] m_item_start,
    output logic [15:0] m_item_length,
    output logic [15:0] m_value_start,
    output logic [15:0] m_value_length,
    output logic [2:0]  m_record_type,
    output logic        m_status,
    output logic        m_last_result
);

    logic                   in_valid_reg;
    logic [7:0]             in_data_reg;
    logic                   in_last_reg;
    logic                   advance;
    logic                   q_can_accept;
    blsplit_pkg::step_out_t step_out;
    blsplit_pkg::result_t   out_res;

    assign advance = in_valid_reg && q_can_accept;
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data_byte;
            in_last_reg <= s_last_byte;
        end
    end

    blsplit_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (advance),
        .data_byte  (in_data_reg),
        .last_byte  (in_last_reg),
        .step_out   (step_out)
    );

    blsplit_out_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_out   (step_out),
        .can_accept (q_can_accept),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_res    (out_res)
    );

    assign m_kind         = out_res.kind;
    assign m_item_start   = out_res.item_start;
    assign m_item_length  = out_res.item_length;
    assign m_value_start  = out_res.value_start;
    assign m_value_length = out_res.value_length;
    assign m_record_type  = out_res.record_type;
    assign m_status       = out_res.status;
    assign m_last_result  = out_res.last_result;

endmodule

/* rtl/blsplit_parser.sv */
// Per-byte record parser holding the segment state and forming result transactions.
module blsplit_parser (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  item_valid,
    input  logic [7:0]            data_byte,
    input  logic                  last_byte,
    output blsplit_pkg::step_out_t step_out
);

    logic [blsplit_pkg::POS_W-1:0] pos_reg, pos_next;
    logic                          ovf_reg, ovf_next;
    blsplit_pkg::mode_t            mode_reg, mode_next;
    logic [blsplit_pkg::POS_W-1:0] seg_begin_reg, seg_begin_next;
    logic [blsplit_pkg::OFS_W-1:0] first_ns_reg, first_ns_next;
    logic [blsplit_pkg::OFS_W-1:0] last_ns_reg, last_ns_next;
    logic                          seen_ns_reg, seen_ns_next;
    logic                          colon_reg, colon_next;
    logic [blsplit_pkg::OFS_W-1:0] key_last_reg, key_last_next;
    logic                          key_text_reg, key_text_next;
    logic [blsplit_pkg::OFS_W-1:0] val_first_reg, val_first_next;
    logic                          val_text_reg, val_text_next;
    logic                          all_space_reg, all_space_next;
    logic                          rec_err_reg, rec_err_next;
    logic                          aborted_reg, aborted_next;

    logic                          ws;
    logic                          ovf_now;
    logic                          active;
    logic                          close_seg;
    logic                          has_seg;
    logic                          match;
    logic [blsplit_pkg::OFS_W-1:0] p16;
    blsplit_pkg::rtype_t           rt;
    blsplit_pkg::result_t          seg_res;
    blsplit_pkg::result_t          end_res;
    logic                          seg_valid;
    logic                          end_valid;

    always_comb begin
        ws      = blsplit_pkg::is_space(data_byte);
        p16     = pos_reg[blsplit_pkg::OFS_W-1:0];
        ovf_now = ovf_reg || (pos_reg == blsplit_pkg::POS_W'(blsplit_pkg::MAX_RECORD_LEN));
        active  = ((mode_reg == blsplit_pkg::MODE_ARRAY) ||
                   (mode_reg == blsplit_pkg::MODE_OBJECT)) && !aborted_reg && !ovf_now;
        has_seg = pos_reg > seg_begin_reg;
        match   = ((mode_reg == blsplit_pkg::MODE_ARRAY) && (data_byte == blsplit_pkg::CHAR_RBRACK))
               || ((mode_reg == blsplit_pkg::MODE_OBJECT) && (data_byte == blsplit_pkg::CHAR_RBRACE));

        pos_next       = pos_reg;
        ovf_next       = ovf_now;
        mode_next      = mode_reg;
        seg_begin_next = seg_begin_reg;
        first_ns_next  = first_ns_reg;
        last_ns_next   = last_ns_reg;
        seen_ns_next   = seen_ns_reg;
        colon_next     = colon_reg;
        key_last_next  = key_last_reg;
        key_text_next  = key_text_reg;
        val_first_next = val_first_reg;
        val_text_next  = val_text_reg;
        all_space_next = all_space_reg;
        rec_err_next   = rec_err_reg;
        aborted_next   = aborted_reg;
        close_seg      = 1'b0;
        seg_valid      = 1'b0;
        end_valid      = 1'b0;
        rt             = blsplit_pkg::RT_UNKNOWN;

        seg_res              = '0;
        seg_res.kind         = (mode_reg == blsplit_pkg::MODE_OBJECT) ?
                               blsplit_pkg::KIND_PAIR : blsplit_pkg::KIND_ELEMENT;
        seg_res.item_start   = first_ns_reg;
        seg_res.record_type  = blsplit_pkg::RT_ARRAY;
        if (mode_reg == blsplit_pkg::MODE_OBJECT) begin
            seg_res.item_length  = key_last_reg - first_ns_reg + 16'd1;
            seg_res.value_start  = val_first_reg;
            seg_res.value_length = last_ns_reg - val_first_reg + 16'd1;
        end else begin
            seg_res.item_length  = last_ns_reg - first_ns_reg + 16'd1;
        end

        if (!ovf_now) begin
            pos_next = pos_reg + 1'b1;
        end

        if (mode_reg == blsplit_pkg::MODE_WAIT) begin
            if (data_byte == blsplit_pkg::CHAR_LBRACK) begin
                mode_next = blsplit_pkg::MODE_ARRAY;
            end else if (data_byte == blsplit_pkg::CHAR_LBRACE) begin
                mode_next = blsplit_pkg::MODE_OBJECT;
            end else begin
                mode_next = blsplit_pkg::MODE_OTHER;
            end
            if (last_byte) begin
                end_valid = 1'b1;
                rt        = blsplit_pkg::RT_UNKNOWN;
            end
        end else if (!last_byte) begin
            if (!ws) begin
                all_space_next = 1'b0;
            end
            if (active) begin
                if ((data_byte == blsplit_pkg::CHAR_COMMA) && has_seg) begin
                    close_seg = 1'b1;
                end else if (!ws) begin
                    if (!seen_ns_reg) begin
                        first_ns_next = p16;
                        seen_ns_next  = 1'b1;
                    end
                    last_ns_next = p16;
                    if (mode_reg == blsplit_pkg::MODE_OBJECT) begin
                        if (!colon_reg) begin
                            if (data_byte == blsplit_pkg::CHAR_COLON) begin
                                colon_next = 1'b1;
                            end else begin
                                key_last_next = p16;
                                key_text_next = 1'b1;
                            end
                        end else if (!val_text_reg) begin
                            val_first_next = p16;
                            val_text_next  = 1'b1;
                        end
                    end
                end
            end
        end else begin
            close_seg = active;
            end_valid = 1'b1;
            if (!match) begin
                rt = blsplit_pkg::RT_UNKNOWN;
            end else if (all_space_reg) begin
                rt = (mode_reg == blsplit_pkg::MODE_ARRAY) ?
                     blsplit_pkg::RT_EMPTY_ARRAY : blsplit_pkg::RT_EMPTY_OBJECT;
            end else begin
                rt = (mode_reg == blsplit_pkg::MODE_ARRAY) ?
                     blsplit_pkg::RT_ARRAY : blsplit_pkg::RT_OBJECT;
            end
        end

        if (close_seg) begin
            if (has_seg) begin
                if (!seen_ns_reg) begin
                    aborted_next = 1'b1;
                end else if (mode_reg == blsplit_pkg::MODE_ARRAY) begin
                    seg_valid = 1'b1;
                end else if (!colon_reg || !key_text_reg || !val_text_reg) begin
                    rec_err_next = 1'b1;
                end else begin
                    seg_valid = 1'b1;
                end
            end
            seg_begin_next = pos_reg + 1'b1;
            first_ns_next  = '0;
            last_ns_next   = '0;
            seen_ns_next   = 1'b0;
            colon_next     = 1'b0;
            key_last_next  = '0;
            key_text_next  = 1'b0;
            val_first_next = '0;
            val_text_next  = 1'b0;
        end

        end_res             = '0;
        end_res.kind        = blsplit_pkg::KIND_END;
        end_res.record_type = rt;
        end_res.status      = (rt != blsplit_pkg::RT_ARRAY && rt != blsplit_pkg::RT_OBJECT)
                              || aborted_next || rec_err_next || ovf_now;
        end_res.last_result = 1'b1;

        if (end_valid) begin
            pos_next       = '0;
            ovf_next       = 1'b0;
            mode_next      = blsplit_pkg::MODE_WAIT;
            seg_begin_next = blsplit_pkg::POS_W'(1);
            first_ns_next  = '0;
            last_ns_next   = '0;
            seen_ns_next   = 1'b0;
            colon_next     = 1'b0;
            key_last_next  = '0;
            key_text_next  = 1'b0;
            val_first_next = '0;
            val_text_next  = 1'b0;
            all_space_next = 1'b1;
            rec_err_next   = 1'b0;
            aborted_next   = 1'b0;
        end

        step_out.seg_valid = item_valid && seg_valid;
        step_out.seg_res   = seg_res;
        step_out.end_valid = item_valid && end_valid;
        step_out.end_res   = end_res;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            ovf_reg       <= 1'b0;
            mode_reg      <= blsplit_pkg::MODE_WAIT;
            seg_begin_reg <= blsplit_pkg::POS_W'(1);
            first_ns_reg  <= '0;
            last_ns_reg   <= '0;
            seen_ns_reg   <= 1'b0;
            colon_reg     <= 1'b0;
            key_last_reg  <= '0;
            key_text_reg  <= 1'b0;
            val_first_reg <= '0;
            val_text_reg  <= 1'b0;
            all_space_reg <= 1'b1;
            rec_err_reg   <= 1'b0;
            aborted_reg   <= 1'b0;
        end else if (item_valid) begin
            pos_reg       <= pos_next;
            ovf_reg       <= ovf_next;
            mode_reg      <= mode_next;
            seg_begin_reg <= seg_begin_next;
            first_ns_reg  <= first_ns_next;
            last_ns_reg   <= last_ns_next;
            seen_ns_reg   <= seen_ns_next;
            colon_reg     <= colon_next;
            key_last_reg  <= key_last_next;
            key_text_reg  <= key_text_next;
            val_first_reg <= val_first_next;
            val_text_reg  <= val_text_next;
            all_space_reg <= all_space_next;
            rec_err_reg   <= rec_err_next;
            aborted_reg   <= aborted_next;
        end
    end

endmodule

/* rtl/blsplit_out_queue.sv */
// Small result queue taking up to two result transactions per cycle.
module blsplit_out_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  blsplit_pkg::step_out_t step_out,
    output logic                   can_accept,
    output logic                   out_valid,
    input  logic                   out_ready,
    output blsplit_pkg::result_t   out_res
);

    blsplit_pkg::result_t            mem_reg [blsplit_pkg::QUEUE_DEPTH];
    logic [blsplit_pkg::QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [blsplit_pkg::QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [blsplit_pkg::QCNT_W-1:0]  count_reg, count_next;
    logic [blsplit_pkg::QPTR_W-1:0]  wr_ptr_second;
    blsplit_pkg::result_t            first_res;
    logic                            push_first;
    logic                            push_second;
    logic                            pop;

    always_comb begin
        push_first    = step_out.seg_valid || step_out.end_valid;
        push_second   = step_out.seg_valid && step_out.end_valid;
        first_res     = step_out.seg_valid ? step_out.seg_res : step_out.end_res;
        wr_ptr_second = wr_ptr_reg + 1'b1;
        pop           = out_valid && out_ready;
        wr_ptr_next   = wr_ptr_reg + blsplit_pkg::QPTR_W'(push_first)
                                   + blsplit_pkg::QPTR_W'(push_second);
        rd_ptr_next   = rd_ptr_reg + blsplit_pkg::QPTR_W'(pop);
        count_next    = count_reg + blsplit_pkg::QCNT_W'(push_first)
                                  + blsplit_pkg::QCNT_W'(push_second)
                                  - blsplit_pkg::QCNT_W'(pop);
        can_accept    = count_reg <= blsplit_pkg::QCNT_W'(blsplit_pkg::QUEUE_DEPTH - 2);
        out_valid     = count_reg != '0;
        out_res       = mem_reg[rd_ptr_reg];
    end

    always_ff @(posedge aclk) begin
        if (push_first) begin
            mem_reg[wr_ptr_reg] <= first_res;
        end
        if (push_second) begin
            mem_reg[wr_ptr_second] <= step_out.end_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* tb/tb_bracketed_list_splitter_core.sv */
// Self-checking testbench for the bracketed list splitter core.
`timescale 1ns / 1ps

module tb_bracketed_list_splitter_core;

    typedef logic [7:0] byte_q_t[$];

    class splitter_tracker;
        blsplit_pkg::result_t pending_items[$];
        int unsigned          failures;
        int unsigned          byte_pos;
        int unsigned          seg_begin;
        int unsigned          first_text;
        int unsigned          last_text;
        int unsigned          key_last;
        int unsigned          value_first;
        bit                   overflow;
        bit                   seen_text;
        bit                   colon_seen;
        bit                   key_text;
        bit                   value_text;
        bit                   interior_blank;
        bit                   bad_pair;
        bit                   abandoned;
        blsplit_pkg::mode_t   mode;

        function new();
            failures = 0;
            restart();
        endfunction

        function void clear_segment();
            first_text = 0;
            last_text = 0;
            seen_text = 0;
            colon_seen = 0;
            key_last = 0;
            key_text = 0;
            value_first = 0;
            value_text = 0;
        endfunction

        function void restart();
            byte_pos = 0;
            overflow = 0;
            mode = blsplit_pkg::MODE_WAIT;
            seg_begin = 1;
            clear_segment();
            interior_blank = 1;
            bad_pair = 0;
            abandoned = 0;
        endfunction

        function bit is_blank(logic [7:0] c);
            return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
        endfunction

        function void push_item(blsplit_pkg::kind_t k, int unsigned i_start,
                                int unsigned i_len, int unsigned v_start,
                                int unsigned v_len, blsplit_pkg::rtype_t rt,
                                bit st, bit lr);
            blsplit_pkg::result_t r;
            r.kind = k;
            r.item_start = i_start[15:0];
            r.item_length = i_len[15:0];
            r.value_start = v_start[15:0];
            r.value_length = v_len[15:0];
            r.record_type = rt;
            r.status = st;
            r.last_result = lr;
            pending_items.push_back(r);
        endfunction

        function void close_segment(int unsigned p);
            if (p > seg_begin) begin
                if (!seen_text) begin
                    abandoned = 1;
                end else if (mode == blsplit_pkg::MODE_ARRAY) begin
                    push_item(blsplit_pkg::KIND_ELEMENT, first_text,
                              last_text - first_text + 1, 0, 0,
                              blsplit_pkg::RT_ARRAY, 0, 0);
                end else if (!colon_seen || !key_text || !value_text) begin
                    bad_pair = 1;
                end else begin
                    push_item(blsplit_pkg::KIND_PAIR, first_text, key_last - first_text + 1,
                              value_first, last_text - value_first + 1,
                              blsplit_pkg::RT_ARRAY, 0, 0);
                end
            end
            seg_begin = p + 1;
            clear_segment();
        endfunction

        function void take_byte(logic [7:0] c, logic last);
            int unsigned         p;
            bit                  ws;
            bit                  live;
            bit                  closer_ok;
            blsplit_pkg::rtype_t rt;
            bit                  st;
            p = byte_pos;
            ws = is_blank(c);
            if (p >= blsplit_pkg::MAX_RECORD_LEN) overflow = 1;
            else byte_pos = p + 1;
            if (mode == blsplit_pkg::MODE_WAIT) begin
                mode = (c == blsplit_pkg::CHAR_LBRACK) ? blsplit_pkg::MODE_ARRAY :
                       (c == blsplit_pkg::CHAR_LBRACE) ? blsplit_pkg::MODE_OBJECT :
                       blsplit_pkg::MODE_OTHER;
                if (last) begin
                    push_item(blsplit_pkg::KIND_END, 0, 0, 0, 0, blsplit_pkg::RT_UNKNOWN, 1, 1);
                    restart();
                end
                return;
            end
            live = (mode == blsplit_pkg::MODE_ARRAY || mode == blsplit_pkg::MODE_OBJECT) &&
                   !abandoned && !overflow;
            if (!last) begin
                if (!ws) interior_blank = 0;
                if (!live) return;
                if (c == blsplit_pkg::CHAR_COMMA && p > seg_begin) begin
                    close_segment(p);
                    return;
                end
                if (!ws) begin
                    if (!seen_text) begin
                        first_text = p;
                        seen_text = 1;
                    end
                    last_text = p;
                    if (mode == blsplit_pkg::MODE_OBJECT) begin
                        if (!colon_seen) begin
                            if (c == blsplit_pkg::CHAR_COLON) begin
                                colon_seen = 1;
                            end else begin
                                key_last = p;
                                key_text = 1;
                            end
                        end else if (!value_text) begin
                            value_first = p;
                            value_text = 1;
                        end
                    end
                end
                return;
            end
            closer_ok = (mode == blsplit_pkg::MODE_ARRAY && c == blsplit_pkg::CHAR_RBRACK) ||
                        (mode == blsplit_pkg::MODE_OBJECT && c == blsplit_pkg::CHAR_RBRACE);
            if (live) close_segment(p);
            if (!closer_ok) rt = blsplit_pkg::RT_UNKNOWN;
            else if (interior_blank)
                rt = (mode == blsplit_pkg::MODE_ARRAY) ? blsplit_pkg::RT_EMPTY_ARRAY :
                                                         blsplit_pkg::RT_EMPTY_OBJECT;
            else
                rt = (mode == blsplit_pkg::MODE_ARRAY) ? blsplit_pkg::RT_ARRAY :
                                                         blsplit_pkg::RT_OBJECT;
            st = (rt > blsplit_pkg::RT_OBJECT) || abandoned || bad_pair || overflow;
            push_item(blsplit_pkg::KIND_END, 0, 0, 0, 0, rt, st, 1);
            restart();
        endfunction

        function void compare(string field, int unsigned want_v, int unsigned got_v);
            if (want_v != got_v) begin
                failures++;
                $display("%0t: %s expected %0d, actual %0d", $time, field, want_v, got_v);
            end
        endfunction

        function void check_item(blsplit_pkg::result_t got);
            blsplit_pkg::result_t want;
            if (pending_items.size() == 0) begin
                failures++;
                $display("%0t: unexpected result, kind %0d start %0d length %0d", $time,
                         got.kind, got.item_start, got.item_length);
                return;
            end
            want = pending_items.pop_front();
            compare("m_kind", want.kind, got.kind);
            compare("m_item_start", want.item_start, got.item_start);
            compare("m_item_length", want.item_length, got.item_length);
            compare("m_value_start", want.value_start, got.value_start);
            compare("m_value_length", want.value_length, got.value_length);
            compare("m_record_type", want.record_type, got.record_type);
            compare("m_status", want.status, got.status);
            compare("m_last_result", want.last_result, got.last_result);
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = 8'h00;
    logic        s_last_byte = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_kind;
    logic [15:0] m_item_start;
    logic [15:0] m_item_length;
    logic [15:0] m_value_start;
    logic [15:0] m_value_length;
    logic [2:0]  m_record_type;
    logic        m_status;
    logic        m_last_result;

    splitter_tracker trk = new();

    bracketed_list_splitter_core dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_last_byte    (s_last_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_item_start   (m_item_start),
        .m_item_length  (m_item_length),
        .m_value_start  (m_value_start),
        .m_value_length (m_value_length),
        .m_record_type  (m_record_type),
        .m_status       (m_status),
        .m_last_result  (m_last_result)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] text_char();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 12) return 8'($urandom_range(0, 255));
        if (r < 22) return 8'($urandom_range(8'h30, 8'h39));
        return 8'($urandom_range(8'h61, 8'h7A));
    endfunction

    function automatic logic [7:0] space_char();
        if ($urandom_range(0, 3) == 0) return 8'($urandom_range(8'h09, 8'h0D));
        return blsplit_pkg::CHAR_SPACE;
    endfunction

    function automatic void add_pad(ref byte_q_t rec);
        int unsigned n;
        n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0;
        repeat (n) rec.push_back(space_char());
    endfunction

    function automatic void add_text(ref byte_q_t rec);
        int unsigned n;
        n = $urandom_range(1, 3);
        repeat (n) rec.push_back(text_char());
    endfunction

    function automatic byte_q_t random_record();
        byte_q_t     rec;
        bit          obj;
        int unsigned segs;
        int unsigned flaw;
        int unsigned r;
        obj = $urandom_range(0, 1);
        r = $urandom_range(0, 99);
        if (r < 3) begin
            rec.push_back(8'($urandom_range(0, 255)));
            return rec;
        end
        rec.push_back(r < 93 ? (obj ? blsplit_pkg::CHAR_LBRACE : blsplit_pkg::CHAR_LBRACK) :
                      8'($urandom_range(0, 255)));
        segs = $urandom_range(0, 4);
        if (segs == 0) add_pad(rec);
        for (int s = 0; s < segs; s++) begin
            if (s != 0) rec.push_back(blsplit_pkg::CHAR_COMMA);
            flaw = $urandom_range(0, 19);
            add_pad(rec);
            if (flaw == 0) begin
                rec.push_back(space_char());
            end else if (flaw == 1) begin
            end else if (!obj) begin
                add_text(rec);
                add_pad(rec);
            end else begin
                if (flaw != 3) add_text(rec);
                add_pad(rec);
                if (flaw != 2) rec.push_back(blsplit_pkg::CHAR_COLON);
                add_pad(rec);
                if (flaw != 4) add_text(rec);
                add_pad(rec);
            end
        end
        if ($urandom_range(0, 7) == 0) rec.push_back(blsplit_pkg::CHAR_COMMA);
        r = $urandom_range(0, 99);
        if (r < 88)
            rec.push_back(obj ? blsplit_pkg::CHAR_RBRACE : blsplit_pkg::CHAR_RBRACK);
        else if (r < 94)
            rec.push_back(obj ? blsplit_pkg::CHAR_RBRACK : blsplit_pkg::CHAR_RBRACE);
        else
            rec.push_back(8'($urandom_range(0, 255)));
        return rec;
    endfunction

    task automatic send_byte(input logic [7:0] d, input logic l);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data_byte <= d;
        s_last_byte <= l;
        do @(posedge aclk); while (!s_ready);
        trk.take_byte(d, l);
    endtask

    task automatic send_record(input byte_q_t rec);
        for (int i = 0; i < rec.size(); i++) send_byte(rec[i], i == rec.size() - 1);
    endtask

    task automatic send_text(input string t);
        for (int i = 0; i < t.len(); i++) send_byte(t[i], i == t.len() - 1);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (trk.pending_items.size() != 0);
    endtask

    initial begin
        int unsigned          hold;
        blsplit_pkg::result_t got;
        hold = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                got.kind = blsplit_pkg::kind_t'(m_kind);
                got.item_start = m_item_start;
                got.item_length = m_item_length;
                got.value_start = m_value_start;
                got.value_length = m_value_length;
                got.record_type = blsplit_pkg::rtype_t'(m_record_type);
                got.status = m_status;
                got.last_result = m_last_result;
                trk.check_item(got);
            end
            if (hold != 0) begin
                hold--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) hold = pick_gap();
            end
        end
    end

    initial begin
        byte_q_t     rec;
        int unsigned sent;
        int unsigned waited;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        send_text("[a, b ,c]");
        send_text("{ k:v ,key : val}");
        send_text("{a:b:c}");
        send_text("[x, ,y,z]");
        send_text("{a,:b,c:}");
        send_text("[,a,,b,]");
        send_text("{p:q,}");
        send_text("(ab)");
        send_text("[a}");
        send_text("]");
        send_text("[ \t\n\013\014\015]");
        send_text("{}");
        send_text("[]");
        send_record('{blsplit_pkg::CHAR_LBRACE, 8'h80, blsplit_pkg::CHAR_COLON, 8'hFF,
                      blsplit_pkg::CHAR_COMMA, 8'h00, blsplit_pkg::CHAR_COLON, 8'h7F,
                      blsplit_pkg::CHAR_RBRACE});
        drain_results();

        sent = 0;
        while (sent < 300) begin
            rec = random_record();
            send_record(rec);
            sent += rec.size();
        end
        s_valid <= 1'b0;

        waited = 0;
        while (trk.pending_items.size() != 0 && waited < 20000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (10) @(posedge aclk);
        if (trk.pending_items.size() != 0) begin
            trk.failures++;
            $display("%0t: %0d expected results never arrived", $time,
                     trk.pending_items.size());
        end
        if (trk.failures == 0) begin
            $display("bracketed_list_splitter_core: match");
        end else begin
            $display("bracketed_list_splitter_core: mismatch");
        end
        $finish;
    end

    initial begin
        #36_000_000;
        $display("bracketed_list_splitter_core: mismatch");
        $finish;
    end

endmodule
